>>> hdl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the echo ranger
// widths, register indexes, phase and sequencer encodings, link structs
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // echo counter width, legal range 10..32
  localparam int COUNT_W   = 16;
  localparam int CNT_W     = $clog2(COUNT_W);
  localparam int CMP_W     = (COUNT_W > 16) ? COUNT_W : 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int DIST_W    = 10;
  localparam int DIGIT_W   = 4;
  localparam int DIV_W     = 8;
  localparam int ALU_W     = 10;

  localparam logic [DIST_W-1:0] DIST_MAX = 10'd999;
  localparam logic [ALU_W-1:0]  HUNDRED  = 10'd100;
  localparam logic [ALU_W-1:0]  TEN      = 10'd10;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ECHO_LIMIT    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_PER_CM  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALERT_CM      = 2'd3;

  localparam logic [7:0]        RST_TRIGGER_TICKS = 8'd10;
  localparam logic [15:0]       RST_ECHO_LIMIT    = 16'd38000;
  localparam logic [DIV_W-1:0]  RST_TICKS_PER_CM  = 8'd59;
  localparam logic [DIST_W-1:0] RST_ALERT_CM      = 10'd30;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_COUNT
  } phase_t;

  typedef enum logic {
    TS_READY,
    TS_CALC
  } top_state_t;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_DIV,
    AR_HUND,
    AR_TENS
  } ar_state_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] dividend;
    logic [DIV_W-1:0]   divisor;
  } ar_req_t;

  typedef struct packed {
    logic               done;
    logic [DIST_W-1:0]  distance;
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } ar_res_t;

endpackage

`default_nettype wire

>>> hdl/uer_if.sv
// ----------------------------------------------------------------------------
// uer_if: request channels of the echo ranger
// tick channel into the block and result channel out of it
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_in_if import uer_pkg::*; ();
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if import uer_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               trigger_out;
  logic               busy_res;
  logic               done_res;
  logic [DIST_W-1:0]  distance_cm;
  logic [DIGIT_W-1:0] digit_hundreds;
  logic [DIGIT_W-1:0] digit_tens;
  logic [DIGIT_W-1:0] digit_units;
  logic               alert;
  logic               out_of_range;

  modport source (output valid, output trigger_out, output busy_res, output done_res,
                  output distance_cm, output digit_hundreds, output digit_tens,
                  output digit_units, output alert, output out_of_range, input ready);
  modport sink   (input valid, input trigger_out, input busy_res, input done_res,
                  input distance_cm, input digit_hundreds, input digit_tens,
                  input digit_units, input alert, input out_of_range, output ready);
endinterface

`default_nettype wire

>>> hdl/uer_sub_unit.sv
// ----------------------------------------------------------------------------
// uer_sub_unit: shared compare and subtract
// gives a - b and whether a >= b
// ----------------------------------------------------------------------------
`default_nettype none

module uer_sub_unit import uer_pkg::*; (
  input  wire logic [ALU_W-1:0] a,
  input  wire logic [ALU_W-1:0] b,
  output logic      [ALU_W-1:0] diff,
  output logic                  ge
);

  logic [ALU_W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[ALU_W-1:0];
  assign ge   = ~full[ALU_W];

endmodule

`default_nettype wire

>>> hdl/uer_arith_seq.sv
// ----------------------------------------------------------------------------
// uer_arith_seq: division and digit split sequencer
// restoring division one bit a cycle, then digits by repeated subtraction
// ----------------------------------------------------------------------------
`default_nettype none

module uer_arith_seq import uer_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire ar_req_t req,
  output ar_res_t      res
);

  ar_state_t           state_r, state_nxt;
  logic [COUNT_W-1:0]  dvd_r, dvd_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    div_r, div_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ALU_W-1:0]    val_r, val_nxt;
  logic [DIGIT_W-1:0]  hund_r, hund_nxt;
  logic [DIGIT_W-1:0]  tens_r, tens_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;

  logic [ALU_W-1:0]    op_a, op_b, alu_diff;
  logic                alu_ge;
  logic [DIV_W:0]      trial;
  logic                last_bit;
  logic [COUNT_W-1:0]  quot;
  logic [ALU_W-1:0]    quot_sat;
  logic                calc_done;

  uer_sub_unit u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  assign trial    = {rem_r, dvd_r[COUNT_W-1]};
  assign last_bit = (cnt_r == CNT_W'(COUNT_W - 1));
  assign quot     = {dvd_r[COUNT_W-2:0], alu_ge};
  assign quot_sat = (CMP_W'(quot) > CMP_W'(DIST_MAX)) ? DIST_MAX : quot[ALU_W-1:0];

  // operand select for the shared unit
  always_comb begin
    op_a = val_r;
    op_b = HUNDRED;
    case (state_r)
      AR_DIV:  begin
        op_a = ALU_W'(trial);
        op_b = ALU_W'(div_r);
      end
      AR_HUND: op_b = HUNDRED;
      AR_TENS: op_b = TEN;
      default: op_b = HUNDRED;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      AR_IDLE: if (req.start) state_nxt = AR_DIV;
      AR_DIV:  if (last_bit) state_nxt = AR_HUND;
      AR_HUND: if (!alu_ge) state_nxt = AR_TENS;
      AR_TENS: if (!alu_ge) state_nxt = AR_IDLE;
      default: state_nxt = AR_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    hund_nxt  = hund_r;
    tens_nxt  = tens_r;
    calc_done = 1'b0;
    case (state_r)
      AR_IDLE: begin
        if (req.start) begin
          dvd_nxt = req.dividend;
          rem_nxt = '0;
          // divisor zero acts as one
          div_nxt = (req.divisor == '0) ? DIV_W'(1) : req.divisor;
          cnt_nxt = '0;
        end
      end
      AR_DIV: begin
        rem_nxt = alu_ge ? alu_diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dvd_nxt = quot;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_bit) begin
          val_nxt  = quot_sat;
          hund_nxt = '0;
          tens_nxt = '0;
        end
      end
      AR_HUND: begin
        if (alu_ge) begin
          val_nxt  = alu_diff;
          hund_nxt = hund_r + DIGIT_W'(1);
        end
      end
      AR_TENS: begin
        if (alu_ge) begin
          val_nxt  = alu_diff;
          tens_nxt = tens_r + DIGIT_W'(1);
        end else begin
          calc_done = 1'b1;
        end
      end
      default: calc_done = 1'b0;
    endcase
  end

  // saturated quotient held for the result
  assign dist_nxt = (state_r == AR_DIV && last_bit) ? quot_sat : dist_r;

  assign res = {calc_done, dist_r, hund_r, tens_r, val_r[DIGIT_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    cnt_r  <= cnt_nxt;
    val_r  <= val_nxt;
    hund_r <= hund_nxt;
    tens_r <= tens_nxt;
    dist_r <= dist_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: ultrasonic echo pulse-width rangefinder
// trigger pulse generation, echo width counting and distance conversion
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one request per microsecond tick: start_req and the sampled
//   echo_level. out_ch returns exactly one request per tick: trigger level,
//   busy and done flags, the last distance in cm, its three decimal digits,
//   the alert flag and the out-of-range flag.
//   cfg_we/cfg_addr/cfg_wdata write trigger_ticks, echo_limit, ticks_per_cm
//   and alert_cm; write them only while no tick is in flight.
// tick handling
//   an ordinary tick's result sits in the output register on the next cycle,
//   so ticks may follow back to back while out_ch.ready stays high.
//   the tick on which the echo falls with a count below the limit starts a
//   calculation: the shared subtractor runs one quotient bit a cycle through
//   the restoring division, then peels off hundreds and tens one at a time.
//   in_ch is not ready during the calculation.
// reset
//   synchronous active-low rst_n: idle phase, counts and last distance zero,
//   registers back to their defaults, output register empty.
// stalls
//   a result waits in the output register while out_ch.ready is low; a new
//   tick is taken in the same cycle the held result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger import uer_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  uer_in_if.sink                     in_ch,
  uer_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [7:0]        trigger_ticks_r;
  logic [15:0]       echo_limit_r;
  logic [DIV_W-1:0]  ticks_per_cm_r;
  logic [DIST_W-1:0] alert_cm_r;

  // measurement state
  phase_t             phase_r, phase_nxt;
  logic [7:0]         trig_cnt_r, trig_cnt_nxt;
  logic [COUNT_W-1:0] echo_cnt_r, echo_cnt_nxt;
  logic [DIST_W-1:0]  last_dist_r;
  logic               last_over_r;
  logic [DIGIT_W-1:0] dig_h_r, dig_t_r, dig_u_r;

  // request sequencing
  top_state_t ts_r, ts_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_trig_r, out_busy_r, out_done_r;

  logic       accept;
  logic       tick_trig;
  logic       tick_finish;
  logic       tick_over;
  logic       go_calc;
  logic       load_now;
  logic       ar_start;
  logic [7:0] trig_inc;

  ar_req_t ar_req;
  ar_res_t ar_res;

  // -------------------------------------------------------------------------
  // configuration writes
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= RST_TRIGGER_TICKS;
      echo_limit_r    <= RST_ECHO_LIMIT;
      ticks_per_cm_r  <= RST_TICKS_PER_CM;
      alert_cm_r      <= RST_ALERT_CM;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TRIGGER_TICKS: trigger_ticks_r <= cfg_wdata[7:0];
        CFG_ECHO_LIMIT:    echo_limit_r    <= cfg_wdata[15:0];
        CFG_TICKS_PER_CM:  ticks_per_cm_r  <= cfg_wdata[DIV_W-1:0];
        CFG_ALERT_CM:      alert_cm_r      <= cfg_wdata[DIST_W-1:0];
        default:           alert_cm_r      <= alert_cm_r;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // per-tick phase logic
  // -------------------------------------------------------------------------
  assign trig_inc = (trig_cnt_r != 8'hFF) ? (trig_cnt_r + 8'd1) : trig_cnt_r;

  always_comb begin
    phase_nxt    = phase_r;
    trig_cnt_nxt = trig_cnt_r;
    echo_cnt_nxt = echo_cnt_r;
    tick_trig    = 1'b0;
    tick_finish  = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (in_ch.start_req) begin
          // trigger already high on the accepting tick
          tick_trig    = 1'b1;
          trig_cnt_nxt = 8'd1;
          phase_nxt    = (8'd1 >= trigger_ticks_r) ? PH_WAIT : PH_TRIG;
        end
      end
      PH_TRIG: begin
        tick_trig    = 1'b1;
        trig_cnt_nxt = trig_inc;
        if (trig_inc >= trigger_ticks_r) phase_nxt = PH_WAIT;
      end
      PH_WAIT: begin
        // rising tick counts as the first high tick
        if (in_ch.echo_level) begin
          echo_cnt_nxt = COUNT_W'(1);
          phase_nxt    = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (in_ch.echo_level) begin
          if (echo_cnt_r != COUNT_MAX) echo_cnt_nxt = echo_cnt_r + COUNT_W'(1);
        end else begin
          tick_finish = 1'b1;
          phase_nxt   = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  assign tick_over = (CMP_W'(echo_cnt_r) >= CMP_W'(echo_limit_r));
  assign go_calc   = accept && tick_finish && !tick_over;

  // -------------------------------------------------------------------------
  // request sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    ts_nxt = ts_r;
    case (ts_r)
      TS_READY: if (go_calc) ts_nxt = TS_CALC;
      TS_CALC:  if (ar_res.done) ts_nxt = TS_READY;
      default:  ts_nxt = TS_READY;
    endcase
  end

  // request sequencer: outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ar_start    = 1'b0;
    load_now    = 1'b0;
    case (ts_r)
      TS_READY: begin
        in_ch.ready = !out_valid_r || out_ch.ready;
        ar_start    = go_calc;
        load_now    = accept && !go_calc;
      end
      TS_CALC: load_now = ar_res.done;
      default: load_now = 1'b0;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;
  assign ar_req = {ar_start, echo_cnt_r, ticks_per_cm_r};

  uer_arith_seq u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ar_req),
    .res   (ar_res)
  );

  // output register holds until taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load_now) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r        <= TS_READY;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      trig_cnt_r  <= '0;
      echo_cnt_r  <= '0;
      last_dist_r <= '0;
      last_over_r <= 1'b0;
      dig_h_r     <= '0;
      dig_t_r     <= '0;
      dig_u_r     <= '0;
    end else begin
      ts_r        <= ts_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r    <= phase_nxt;
        trig_cnt_r <= trig_cnt_nxt;
        echo_cnt_r <= echo_cnt_nxt;
      end
      if (accept && tick_finish && tick_over) begin
        // out of range: distance zero
        last_dist_r <= '0;
        last_over_r <= 1'b1;
        dig_h_r     <= '0;
        dig_t_r     <= '0;
        dig_u_r     <= '0;
      end else if (ts_r == TS_CALC && ar_res.done) begin
        last_dist_r <= ar_res.distance;
        last_over_r <= 1'b0;
        dig_h_r     <= ar_res.hund;
        dig_t_r     <= ar_res.tens;
        dig_u_r     <= ar_res.units;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_trig_r <= tick_trig;
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_done_r <= tick_finish;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.trigger_out    = out_trig_r;
  assign out_ch.busy_res       = out_busy_r;
  assign out_ch.done_res       = out_done_r;
  assign out_ch.distance_cm    = last_dist_r;
  assign out_ch.digit_hundreds = dig_h_r;
  assign out_ch.digit_tens     = dig_t_r;
  assign out_ch.digit_units    = dig_u_r;
  assign out_ch.alert          = (last_dist_r < alert_cm_r);
  assign out_ch.out_of_range   = last_over_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_done_in_calc : assert property (@(posedge clk) disable iff (!rst_n)
    ar_res.done |-> ts_r == TS_CALC)
    else $error("arithmetic finished outside a calculation");

  a_dist_sat : assert property (@(posedge clk) disable iff (!rst_n)
    last_dist_r <= DIST_MAX)
    else $error("distance above saturation limit");

  a_over_zero : assert property (@(posedge clk) disable iff (!rst_n)
    last_over_r |-> last_dist_r == '0)
    else $error("out of range with nonzero distance");

  a_calc_no_out : assert property (@(posedge clk) disable iff (!rst_n)
    ts_r == TS_CALC |-> !out_valid_r)
    else $error("result pending during a calculation");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_busy_r)
    else $error("done flagged while still busy");

endmodule

`default_nettype wire
